// File: rtl/core/stse_pkg.sv
// shared types and constants of the square tone sweep envelope unit
// depends on nothing; imported by the controller, datapath and top level
package stse_pkg;

   localparam int unsigned TICK_RATE  = 44100;
   localparam int unsigned SWEEP_UNIT = TICK_RATE / 128;
   localparam int unsigned ENV_UNIT   = TICK_RATE / 64;

   localparam int FREQ_W     = 11;
   localparam int VOL_W      = 4;
   localparam int LEN_W      = 17;
   localparam int CNT_W      = 16;
   localparam int REM_W      = 17;
   localparam int AMP_W      = 13;
   localparam int DUTY_W     = 4;
   localparam int LVL_W      = AMP_W + VOL_W;
   localparam int SAMPLE_W   = 16;
   localparam int PROD_W     = $clog2(TICK_RATE * 2048 + 1);
   localparam int PER_SHIFT  = 17;
   localparam int PER_W      = PROD_W - PER_SHIFT;
   localparam int EIGHTH_W   = PER_W - 3;
   localparam int WIN_W      = EIGHTH_W + DUTY_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [FREQ_W:0]     FREQ_LIMIT = (FREQ_W + 1)'(2048);
   localparam logic [VOL_W-1:0]    VOL_MAX    = '1;
   localparam logic [SAMPLE_W-1:0] LEVEL_LOW  = 16'h8000;
   localparam logic [REM_W-1:0]    LEN_RELOAD = REM_W'(TICK_RATE - 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SWEEP_PERIOD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SWEEP_SHIFT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SWEEP_MODE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ENV_PERIOD   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ENV_MODE     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DUTY_START   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DUTY_END     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_AMP_STEP     = 3'd7;

   localparam logic [1:0] SWEEP_UP   = 2'd0;
   localparam logic [1:0] SWEEP_DOWN = 2'd1;
   localparam logic [1:0] SWEEP_HOLD = 2'd2;
   localparam logic [1:0] ENV_DOWN   = 2'd0;
   localparam logic [1:0] ENV_UP     = 2'd1;
   localparam logic [1:0] ENV_HOLD   = 2'd2;

   localparam logic ACTION_TICK    = 1'b0;
   localparam logic ACTION_TRIGGER = 1'b1;

   typedef struct packed {
      logic              action;
      logic [FREQ_W-1:0] start_frequency;
      logic [VOL_W-1:0]  start_volume;
      logic [LEN_W-1:0]  length_ticks;
      logic              length_stop;
      logic              routed;
   } stse_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       playing;
      logic [FREQ_W-1:0]          current_frequency;
   } stse_rsp_type;

   typedef struct packed {
      logic trigger;
      logic sweep_step;
      logic env_step;
      logic phase_step;
      logic load_out;
   } stse_cmd_type;

endpackage

// File: rtl/core/stse_ctrl.sv
// sequencer of the square tone sweep envelope unit: handshakes and step commands
// depends on stse_pkg
module stse_ctrl
   import stse_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_action,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output stse_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SWEEP = 3'd1;
   localparam logic [2:0] ST_ENV   = 3'd2;
   localparam logic [2:0] ST_PHASE = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       accept;
   logic       tick_accept;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == ST_IDLE) || ((state_ff == ST_DONE) && out_free);
   assign accept      = req_valid && req_ready;
   assign tick_accept = accept && (req_action == ACTION_TICK);
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.trigger    = accept && (req_action == ACTION_TRIGGER);
      unique case (state_ff)
         ST_IDLE: begin
            if (tick_accept) state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            state_in       = ST_ENV;
         end
         ST_ENV: begin
            cmd.env_step = 1'b1;
            state_in     = ST_PHASE;
         end
         ST_PHASE: begin
            cmd.phase_step = 1'b1;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = tick_accept ? ST_SWEEP : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_sweep_then_env: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |=> (state_ff == ST_ENV))
      else $error("sweep step not followed by envelope step");

   a_tick_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_action == ACTION_TICK)) |=> (state_ff == ST_SWEEP))
      else $error("accepted tick did not start the sweep step");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

// File: rtl/core/stse_dp.sv
// datapath of the square tone sweep envelope unit: settings, channel state, steps
// depends on stse_pkg; driven by stse_ctrl commands
module stse_dp
   import stse_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  stse_cmd_type          cmd,
   input  stse_req_type          req_item,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output stse_rsp_type          rsp_item
);

   // settings
   logic [2:0]        sweep_period_ff, sweep_shift_ff, env_period_ff;
   logic [1:0]        sweep_mode_ff, env_mode_ff;
   logic [DUTY_W-1:0] duty_start_ff, duty_end_ff;
   logic [AMP_W-1:0]  amp_step_ff;

   // channel state
   logic [FREQ_W-1:0] raw_freq_ff, raw_freq_in;
   logic [VOL_W-1:0]  volume_ff, volume_in;
   logic              channel_on_ff, channel_on_in;
   logic [CNT_W-1:0]  sweep_count_ff, sweep_count_in;
   logic [CNT_W-1:0]  env_count_ff, env_count_in;
   logic [CNT_W-1:0]  phase_count_ff, phase_count_in;
   logic [REM_W-1:0]  remaining_ff, remaining_in;
   logic              stop_at_end_ff, stop_at_end_in;
   logic              routed_ff, routed_in;

   // per-tick working registers
   logic                active_ff, active_in;
   logic                stopped_ff, stopped_in;
   logic [PROD_W-1:0]   period_prod_ff, period_prod_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   stse_rsp_type        rsp_item_ff, rsp_item_in;

   logic [CNT_W-1:0]    sweep_inc, sweep_thr, env_inc, env_thr, phase_inc, phase_next;
   logic [FREQ_W-1:0]   delta;
   logic [FREQ_W:0]     freq_sum;
   logic [PER_W-1:0]    period;
   logic [EIGHTH_W-1:0] eighth;
   logic [WIN_W-1:0]    win_lo, win_hi;
   logic [LVL_W-1:0]    level_prod;
   logic [SAMPLE_W-1:0] level_sat;
   logic                high;

   assign sweep_inc  = sweep_count_ff + 1'b1;
   assign sweep_thr  = CNT_W'(SWEEP_UNIT * int'(sweep_period_ff));
   assign env_inc    = env_count_ff + 1'b1;
   assign env_thr    = CNT_W'(ENV_UNIT * int'(env_period_ff));
   assign delta      = (sweep_shift_ff != 3'd0) ? (raw_freq_ff >> sweep_shift_ff) : '0;
   assign freq_sum   = {1'b0, raw_freq_ff} + {1'b0, delta};
   assign period     = period_prod_ff[PROD_W-1:PER_SHIFT];
   assign eighth     = period[PER_W-1:3];
   assign win_lo     = WIN_W'(eighth) * WIN_W'(duty_start_ff);
   assign win_hi     = WIN_W'(eighth) * WIN_W'(duty_end_ff);
   assign phase_inc  = phase_count_ff + 1'b1;
   assign phase_next = (phase_inc >= CNT_W'(period)) ? '0 : phase_inc;
   assign level_prod = LVL_W'(amp_step_ff) * LVL_W'(volume_ff);
   assign level_sat  = (level_prod > LVL_W'(65535)) ? '1 : level_prod[SAMPLE_W-1:0];
   assign high       = (phase_next >= CNT_W'(win_lo)) && (phase_next < CNT_W'(win_hi))
                       && (volume_ff != '0);

   always_comb begin
      raw_freq_in    = raw_freq_ff;
      volume_in      = volume_ff;
      channel_on_in  = channel_on_ff;
      sweep_count_in = sweep_count_ff;
      env_count_in   = env_count_ff;
      phase_count_in = phase_count_ff;
      remaining_in   = remaining_ff;
      stop_at_end_in = stop_at_end_ff;
      routed_in      = routed_ff;
      active_in      = active_ff;
      stopped_in     = stopped_ff;
      period_prod_in = period_prod_ff;
      sample_in      = sample_ff;
      rsp_item_in    = rsp_item_ff;

      if (cmd.trigger) begin
         raw_freq_in    = req_item.start_frequency;
         volume_in      = req_item.start_volume;
         remaining_in   = REM_W'(req_item.length_ticks);
         stop_at_end_in = req_item.length_stop;
         routed_in      = req_item.routed;
         channel_on_in  = 1'b1;
         sweep_count_in = '0;
         env_count_in   = '0;
         phase_count_in = '0;
      end

      if (cmd.sweep_step) begin
         active_in  = channel_on_ff && routed_ff;
         stopped_in = 1'b0;
         if (channel_on_ff && routed_ff && (sweep_period_ff != 3'd0)) begin
            sweep_count_in = sweep_inc;
            if (sweep_inc >= sweep_thr) begin
               sweep_count_in = '0;
               if (sweep_mode_ff == SWEEP_UP) begin
                  if (freq_sum >= FREQ_LIMIT) begin
                     volume_in     = '0;
                     channel_on_in = 1'b0;
                     stopped_in    = 1'b1;
                  end else begin
                     raw_freq_in = freq_sum[FREQ_W-1:0];
                  end
               end else if (sweep_mode_ff == SWEEP_DOWN) begin
                  raw_freq_in = raw_freq_ff - delta;
               end
            end
         end
      end

      if (cmd.env_step) begin
         period_prod_in = PROD_W'(TICK_RATE) * PROD_W'(FREQ_LIMIT - {1'b0, raw_freq_ff});
         if (active_ff && !stopped_ff && (env_period_ff != 3'd0)) begin
            env_count_in = env_inc;
            if (env_inc >= env_thr) begin
               env_count_in = '0;
               if ((env_mode_ff == ENV_DOWN) && (volume_ff != '0)) begin
                  volume_in = volume_ff - 1'b1;
               end else if ((env_mode_ff == ENV_UP) && (volume_ff != VOL_MAX)) begin
                  volume_in = volume_ff + 1'b1;
               end
            end
         end
      end

      if (cmd.phase_step) begin
         sample_in = LEVEL_LOW;
         if (active_ff && !stopped_ff) begin
            priority if (remaining_ff != '0) begin
               phase_count_in = phase_next;
               remaining_in   = remaining_ff - 1'b1;
               if (high) sample_in = level_sat + LEVEL_LOW;
            end else if (!stop_at_end_ff) begin
               remaining_in = LEN_RELOAD;
            end else begin
               channel_on_in = 1'b0;
            end
         end
      end

      if (cmd.load_out) begin
         rsp_item_in.sample            = sample_ff;
         rsp_item_in.playing           = channel_on_ff;
         rsp_item_in.current_frequency = raw_freq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_period_ff <= '0;
         sweep_shift_ff  <= '0;
         sweep_mode_ff   <= SWEEP_HOLD;
         env_period_ff   <= '0;
         env_mode_ff     <= ENV_HOLD;
         duty_start_ff   <= '0;
         duty_end_ff     <= DUTY_W'(4);
         amp_step_ff     <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_SWEEP_PERIOD: sweep_period_ff <= csr_data[2:0];
            REG_SWEEP_SHIFT:  sweep_shift_ff  <= csr_data[2:0];
            REG_SWEEP_MODE:   sweep_mode_ff   <= csr_data[1:0];
            REG_ENV_PERIOD:   env_period_ff   <= csr_data[2:0];
            REG_ENV_MODE:     env_mode_ff     <= csr_data[1:0];
            REG_DUTY_START:   duty_start_ff   <= csr_data[DUTY_W-1:0];
            REG_DUTY_END:     duty_end_ff     <= csr_data[DUTY_W-1:0];
            REG_AMP_STEP:     amp_step_ff     <= csr_data[AMP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_freq_ff    <= '0;
         volume_ff      <= '0;
         channel_on_ff  <= 1'b0;
         sweep_count_ff <= '0;
         env_count_ff   <= '0;
         phase_count_ff <= '0;
         remaining_ff   <= '0;
         stop_at_end_ff <= 1'b0;
         routed_ff      <= 1'b0;
         active_ff      <= 1'b0;
         stopped_ff     <= 1'b0;
      end else begin
         raw_freq_ff    <= raw_freq_in;
         volume_ff      <= volume_in;
         channel_on_ff  <= channel_on_in;
         sweep_count_ff <= sweep_count_in;
         env_count_ff   <= env_count_in;
         phase_count_ff <= phase_count_in;
         remaining_ff   <= remaining_in;
         stop_at_end_ff <= stop_at_end_in;
         routed_ff      <= routed_in;
         active_ff      <= active_in;
         stopped_ff     <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      period_prod_ff <= period_prod_in;
      sample_ff      <= sample_in;
      rsp_item_ff    <= rsp_item_in;
   end

   assign rsp_item = rsp_item_ff;

   a_overflow_silences: assert property (@(posedge clock) disable iff (reset)
      (cmd.env_step && stopped_ff) |-> (!channel_on_ff && (volume_ff == '0)))
      else $error("sweep overflow left the channel sounding");

endmodule

// File: rtl/core/square_tone_sweep_envelope_unit.sv
// Pulse tone channel with frequency sweep, volume envelope and length control.
// A trigger item updates the channel state and gives no result. A tick item runs
// the sweep, envelope and phase steps on a four-step sequencer and gives one
// sample, which is loaded into the output register in the last step; the next
// item can be accepted in that last step, in the same cycle as the load. The
// single output register holds a result until it is taken, and the sequencer
// waits in its last step while that register is still full.
// depends on stse_pkg, stse_ctrl and stse_dp
module square_tone_sweep_envelope_unit
   import stse_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  stse_req_type          req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output stse_rsp_type          rsp_item,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   stse_cmd_type cmd;

   stse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_item.action),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd)
   );

   stse_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_item  (rsp_item)
   );

endmodule
